// ----- rtl/mstt_pkg.sv -----
// ----------------------------------------------------------------------------
// Multi-slot timeout table package
// Request types, mode codes and sequencer states shared by the table's files.
// ----------------------------------------------------------------------------
package mstt_pkg;

  // Request modes carried in the mode field of an input request.
  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_ARM    = 2'd1,
    MODE_CANCEL = 2'd2,
    MODE_SCAN   = 2'd3
  } mode_e;

  // Sequencer states of the core.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  // Width of one slot's start time and of its duration.
  localparam int unsigned TimeW = 32;
  localparam int unsigned DurW  = 16;

  // Input request.
  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  slot_id;
    logic [15:0] duration;
  } in_req_t;

  // Output request: one expired slot.
  typedef struct packed {
    logic [3:0] expired_slot;
    logic       last;
  } out_req_t;

endpackage

// ----- rtl/multi_slot_timeout_table_core.sv -----
// Tick, arm and cancel requests leave the core idle and ready for the next request.
// A scan runs through the accepting request, one slot read from the slot RAM per cycle
// while not held, the check of the registered read data and the release of the final result.
// An output stall holds the scan until the result register is free.
// Reset clears the tick count and every slot's armed bit at once; no sweep.
// ----------------------------------------------------------------------------
// Multi-slot timeout table core
// A 32-bit tick count and a RAM of timeout slots; scans report expired slots.
// ----------------------------------------------------------------------------
module multi_slot_timeout_table_core #(
  parameter int unsigned SLOTS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mstt_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mstt_pkg::out_req_t out_req_o
);

  import mstt_pkg::*;

  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned EntW = TimeW + DurW;

  state_e state_q, state_d;

  logic [TimeW-1:0] now_q, now_d;
  logic [SLOTS-1:0] wr_vld_q, wr_vld_d;
  logic [CW-1:0]    issue_idx_q, issue_idx_d;
  logic             eval_vld_q, eval_vld_d;
  logic [SW-1:0]    eval_idx_q, eval_idx_d;
  logic             pend_vld_q, pend_vld_d;
  logic [SW-1:0]    pend_idx_q, pend_idx_d;
  logic             out_vld_q, out_vld_d;
  out_req_t         out_q, out_d;

  logic             in_acc;
  logic             id_ok;
  logic [SW-1:0]    id_addr;
  logic             ram_we;
  logic             ram_re;
  logic [EntW-1:0]  ram_rdata;
  logic [TimeW-1:0] ent_start;
  logic [DurW-1:0]  ent_dur;
  logic [TimeW-1:0] elapsed;
  logic             hit;
  logic             out_busy;
  logic             hold;
  logic             issue_done;

  // The input is taken only while no scan is in progress.
  assign in_stall_o = (state_q != ST_IDLE);

  assign in_acc  = in_valid_i && !in_stall_o;
  assign id_ok   = (32'(in_req_i.slot_id) < SLOTS);
  assign id_addr = SW'(in_req_i.slot_id);
  assign ram_we  = in_acc && (in_req_i.mode == MODE_ARM) && id_ok;

  // Slot RAM: start time in the upper bits, duration in the lower bits.
  mstt_ram #(
    .WIDTH(EntW),
    .DEPTH(SLOTS)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(id_addr),
    .wdata_i({now_q, in_req_i.duration}),
    .re_i   (ram_re),
    .raddr_i(issue_idx_q[SW-1:0]),
    .rdata_o(ram_rdata)
  );

  // Expiry test on the slot read last cycle; an unarmed slot never fires.
  assign ent_start = ram_rdata[EntW-1:DurW];
  assign ent_dur   = ram_rdata[DurW-1:0];
  assign elapsed   = now_q - ent_start;
  assign hit       = eval_vld_q && wr_vld_q[eval_idx_q] && (ent_dur != '0) &&
                     (elapsed > TimeW'(ent_dur));

  // The scan pauses when a found slot must displace a pending one into a full
  // result register.
  assign out_busy   = out_vld_q && out_stall_i;
  assign hold       = hit && pend_vld_q && out_busy;
  assign issue_done = (issue_idx_q == CW'(SLOTS));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_req_i.mode == MODE_SCAN)) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!hold && issue_done) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!pend_vld_q || !out_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath control and outputs.
  always_comb begin
    now_d       = now_q;
    wr_vld_d    = wr_vld_q;
    issue_idx_d = issue_idx_q;
    eval_vld_d  = eval_vld_q;
    eval_idx_d  = eval_idx_q;
    pend_vld_d  = pend_vld_q;
    pend_idx_d  = pend_idx_q;
    ram_re      = 1'b0;
    out_vld_d   = out_vld_q && out_stall_i;
    out_d       = out_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_req_i.mode)
            MODE_TICK: now_d = now_q + 1'b1;
            MODE_ARM: begin
              if (id_ok) begin
                wr_vld_d[id_addr] = 1'b1;
              end
            end
            MODE_CANCEL: begin
              // An unwritten entry reads as disarmed.
              if (id_ok) begin
                wr_vld_d[id_addr] = 1'b0;
              end
            end
            default: begin
              issue_idx_d = '0;
              eval_vld_d  = 1'b0;
              pend_vld_d  = 1'b0;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (!hold) begin
          // Issue the next slot read.
          if (!issue_done) begin
            ram_re      = 1'b1;
            eval_vld_d  = 1'b1;
            eval_idx_d  = issue_idx_q[SW-1:0];
            issue_idx_d = issue_idx_q + 1'b1;
          end else begin
            eval_vld_d = 1'b0;
          end
          // A new hit releases the pending one, which is then known not last.
          if (hit) begin
            if (pend_vld_q) begin
              out_vld_d          = 1'b1;
              out_d.expired_slot = 4'(pend_idx_q);
              out_d.last         = 1'b0;
            end
            pend_vld_d = 1'b1;
            pend_idx_d = eval_idx_q;
          end
        end
      end
      ST_FLUSH: begin
        // The pending slot is the final one of this scan.
        if (pend_vld_q && !out_busy) begin
          out_vld_d          = 1'b1;
          out_d.expired_slot = 4'(pend_idx_q);
          out_d.last         = 1'b1;
          pend_vld_d         = 1'b0;
        end
      end
      default: begin
        pend_vld_d = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      now_q       <= '0;
      wr_vld_q    <= '0;
      issue_idx_q <= '0;
      eval_vld_q  <= 1'b0;
      pend_vld_q  <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      now_q       <= now_d;
      wr_vld_q    <= wr_vld_d;
      issue_idx_q <= issue_idx_d;
      eval_vld_q  <= eval_vld_d;
      pend_vld_q  <= pend_vld_d;
      out_vld_q   <= out_vld_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    eval_idx_q <= eval_idx_d;
    pend_idx_q <= pend_idx_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_req_o   = out_q;

endmodule

// ----- rtl/mstt_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds without re_i.
// ----------------------------------------------------------------------------
module mstt_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Storage array write.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/mstt_checker.sv -----
// ----------------------------------------------------------------------------
// Multi-slot timeout table port checker
// Watches the core's ports over time; bound to the core module below.
// ----------------------------------------------------------------------------
module mstt_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input mstt_pkg::in_req_t  in_req_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input mstt_pkg::out_req_t out_req_o
);

  import mstt_pkg::*;

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_req_o))
    else $error("stalled result changed");

  // A scan request occupies the core on the following cycle.
  a_scan_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_req_i.mode == MODE_SCAN) |=> in_stall_o)
    else $error("scan request did not occupy the core");

  // Tick, arm and cancel requests leave the core free on the following cycle.
  a_short_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_req_i.mode != MODE_SCAN) |=> !in_stall_o)
    else $error("short request kept the core busy");

  // Once the core is free again, only the final result of a scan can remain.
  a_idle_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o && out_valid_o |-> out_req_o.last)
    else $error("non-final result left after scan completed");

endmodule

bind multi_slot_timeout_table_core mstt_checker u_mstt_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .in_req_i   (in_req_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_req_o  (out_req_o)
);
